[design/mlc_pkg.sv]
// ----------------------------------------------------------------------------
// mlc_pkg - shared types and constants of the markdown line classifier
// Byte codes, line kinds, heading scan phases and the per-line control
// record handed from the front end to the back end.
// ----------------------------------------------------------------------------
package mlc_pkg;

    // Field widths of the result word
    localparam int FIELD_W     = 16;
    localparam int LEVEL_W     = 3;
    localparam int KIND_W      = 2;
    localparam int BYTE_W      = 8;
    localparam int OUT_TDATA_W = 40;

    // Deepest heading level and shortest rule line
    localparam logic [LEVEL_W-1:0] MAX_HEADING_LEVEL = 3'd6;
    localparam int                 MIN_RULE_LEN      = 3;

    // Byte codes
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    // Kind of an emitted line record
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADING = 2'd0,
        KIND_RULE    = 2'd1,
        KIND_PARA    = 2'd2
    } t_line_kind;

    // Heading scan phase within a line
    typedef enum logic [1:0] {
        PH_COUNT = 2'd0,
        PH_GAP   = 2'd1,
        PH_TEXT  = 2'd2,
        PH_FAIL  = 2'd3
    } t_hd_phase;

    // Control part of a closed line
    typedef struct packed {
        t_line_kind          kind;
        logic [LEVEL_W-1:0]  level;
        logic                text_found;
    } t_line_ctl;

endpackage

[design/markdown_line_classifier_core.sv]
// ----------------------------------------------------------------------------
// markdown_line_classifier_core - markdown heading / rule / paragraph lines
// A record goes into the two-entry record queue when the byte that closes
// its line is accepted, then to the output register on the master side.
// Throughput: one byte per cycle while the queue has space; the queue and
// the output register keep input and output stalls apart.
// Reset: synchronous, active low; clears all line state, the queue and the
// output valid. No memory clearing pass.
// ----------------------------------------------------------------------------
module markdown_line_classifier_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Byte input
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
    input  logic                                s_axis_tlast,  // end_of_input
    // Line record output
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] level, [18:3] text_offset, [34:19] text_len, [39:35] zero
    output logic [mlc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic [mlc_pkg::KIND_W-1:0]          m_axis_tuser   // [1:0] line_kind
);

    localparam int CTL_W = $bits(mlc_pkg::t_line_ctl);
    localparam int REC_W = CTL_W + 4 * OFFSET_BITS;
    localparam int PAD_W = mlc_pkg::OUT_TDATA_W - mlc_pkg::LEVEL_W - 2 * mlc_pkg::FIELD_W;

    logic                               space, push, avail, pop;
    mlc_pkg::t_line_ctl                 f_ctl, b_ctl;
    logic [OFFSET_BITS-1:0]             f_hts, f_start, f_len, f_trim;
    logic [OFFSET_BITS-1:0]             b_hts, b_start, b_len, b_trim;
    logic [REC_W-1:0]                   q_in, q_out;
    mlc_pkg::t_line_kind                o_kind;
    logic [mlc_pkg::LEVEL_W-1:0]        o_level;
    logic [mlc_pkg::FIELD_W-1:0]        o_offset, o_length;

    // Scan bytes and classify lines
    mlc_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_space  (space),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_hts    (f_hts),
        .o_start  (f_start),
        .o_len    (f_len),
        .o_trim   (f_trim)
    );

    assign q_in = {f_ctl, f_hts, f_start, f_len, f_trim};

    // Queue closed lines
    mlc_queue #(
        .DATA_W(REC_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_space (space),
        .o_avail (avail),
        .o_data  (q_out)
    );

    assign {b_ctl, b_hts, b_start, b_len, b_trim} = q_out;

    // Format and hold records
    mlc_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (avail),
        .o_pop    (pop),
        .i_ctl    (b_ctl),
        .i_hts    (b_hts),
        .i_start  (b_start),
        .i_len    (b_len),
        .i_trim   (b_trim),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_kind   (o_kind),
        .o_level  (o_level),
        .o_offset (o_offset),
        .o_length (o_length)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, o_length, o_offset, o_level};
    assign m_axis_tuser = o_kind;

endmodule

[design/mlc_front.sv]
// ----------------------------------------------------------------------------
// mlc_front - byte scanner and line classifier
// Tracks one line at a time, decides at the line end whether a record is due
// and of which kind, and pushes the raw line facts to the record queue.
// ----------------------------------------------------------------------------
module mlc_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tvalid,
    output logic                               o_tready,
    input  logic [mlc_pkg::BYTE_W-1:0]         i_tdata,
    input  logic                               i_tlast,
    input  logic                               i_space,
    output logic                               o_push,
    output mlc_pkg::t_line_ctl                 o_ctl,
    output logic [OFFSET_BITS-1:0]             o_hts,
    output logic [OFFSET_BITS-1:0]             o_start,
    output logic [OFFSET_BITS-1:0]             o_len,
    output logic [OFFSET_BITS-1:0]             o_trim
);

    localparam int HW = mlc_pkg::LEVEL_W;

    // Line state
    logic [OFFSET_BITS-1:0]        r_byte_ofs, n_byte_ofs;
    logic [OFFSET_BITS-1:0]        r_start, n_start;
    logic [OFFSET_BITS-1:0]        r_len, n_len;
    logic [OFFSET_BITS-1:0]        r_trim, n_trim;
    logic [mlc_pkg::BYTE_W-1:0]    r_first, n_first;
    logic [HW-1:0]                 r_hash, n_hash;
    mlc_pkg::t_hd_phase            r_phase, n_phase;
    logic [OFFSET_BITS-1:0]        r_hts, n_hts;
    logic                          r_rule_ok, n_rule_ok;
    logic                          r_after_cr, n_after_cr;

    logic accept, sp, is_lf, is_cr, is_term, swallow;

    // Line state once the current byte is taken in
    logic [OFFSET_BITS-1:0]        tk_start, tk_len, tk_trim, tk_hts;
    logic [mlc_pkg::BYTE_W-1:0]    tk_first;
    logic [HW-1:0]                 tk_hash;
    mlc_pkg::t_hd_phase            tk_phase;
    logic                          tk_rule_ok;

    // Line state that the record is built from
    logic [OFFSET_BITS-1:0]        cl_start, cl_len, cl_trim, cl_hts;
    logic [mlc_pkg::BYTE_W-1:0]    cl_first;
    logic [HW-1:0]                 cl_hash;
    mlc_pkg::t_hd_phase            cl_phase;
    logic                          cl_rule_ok;
    logic                          cl_marker, do_close, emit;
    mlc_pkg::t_line_kind           cl_kind;

    assign accept   = i_tvalid && i_space;
    assign o_tready = i_space;

    // Decode the byte
    assign sp      = i_tdata inside {mlc_pkg::CH_SPACE, mlc_pkg::CH_TAB};
    assign is_lf   = (i_tdata == mlc_pkg::CH_LF);
    assign is_cr   = (i_tdata == mlc_pkg::CH_CR);
    assign is_term = is_lf || is_cr;
    assign swallow = r_after_cr && is_lf;

    // Take the byte into the open line
    always_comb begin
        tk_start   = (r_len == '0) ? r_byte_ofs : r_start;
        tk_first   = (r_len == '0) ? i_tdata : r_first;
        tk_len     = r_len + OFFSET_BITS'(1);
        tk_trim    = sp ? r_trim : tk_len;
        tk_rule_ok = r_rule_ok && !((i_tdata != tk_first) && !sp);
    end

    // Advance the heading scan phase
    always_comb begin
        tk_hash  = r_hash;
        tk_phase = r_phase;
        tk_hts   = r_hts;
        case (r_phase)
            mlc_pkg::PH_COUNT: begin
                if ((i_tdata == mlc_pkg::CH_HASH) && (r_hash < mlc_pkg::MAX_HEADING_LEVEL)) begin
                    tk_hash = r_hash + HW'(1);
                end else if (sp) begin
                    tk_phase = mlc_pkg::PH_GAP;
                end else begin
                    tk_phase = mlc_pkg::PH_FAIL;
                end
            end
            mlc_pkg::PH_GAP: begin
                if (!sp) begin
                    tk_hts   = r_byte_ofs;
                    tk_phase = mlc_pkg::PH_TEXT;
                end
            end
            default: begin
                tk_phase = r_phase;
            end
        endcase
    end

    // Pick the line image to close: a terminator closes the line as it stood
    always_comb begin
        cl_start   = is_term ? r_start   : tk_start;
        cl_len     = is_term ? r_len     : tk_len;
        cl_trim    = is_term ? r_trim    : tk_trim;
        cl_first   = is_term ? r_first   : tk_first;
        cl_hash    = is_term ? r_hash    : tk_hash;
        cl_phase   = is_term ? r_phase   : tk_phase;
        cl_hts     = is_term ? r_hts     : tk_hts;
        cl_rule_ok = is_term ? r_rule_ok : tk_rule_ok;
    end

    // Classify the closed line
    assign cl_marker = cl_first inside {mlc_pkg::CH_DASH, mlc_pkg::CH_UNDER, mlc_pkg::CH_STAR};
    assign do_close  = accept && !swallow && (is_term || i_tlast);

    always_comb begin
        emit    = 1'b0;
        cl_kind = mlc_pkg::KIND_PARA;
        if (cl_trim != '0) begin
            if (cl_first == mlc_pkg::CH_HASH) begin
                cl_kind = mlc_pkg::KIND_HEADING;
                emit    = (cl_phase != mlc_pkg::PH_FAIL);
            end else if (cl_marker && (cl_len >= OFFSET_BITS'(mlc_pkg::MIN_RULE_LEN))) begin
                cl_kind = mlc_pkg::KIND_RULE;
                emit    = cl_rule_ok;
            end else begin
                cl_kind = mlc_pkg::KIND_PARA;
                emit    = 1'b1;
            end
        end
    end

    assign o_push           = do_close && emit;
    assign o_ctl.kind       = cl_kind;
    assign o_ctl.level      = cl_hash;
    assign o_ctl.text_found = (cl_phase == mlc_pkg::PH_TEXT);
    assign o_hts            = cl_hts;
    assign o_start          = cl_start;
    assign o_len            = cl_len;
    assign o_trim           = cl_trim;

    // Next line state
    always_comb begin
        n_byte_ofs = r_byte_ofs;
        n_start    = r_start;
        n_len      = r_len;
        n_trim     = r_trim;
        n_first    = r_first;
        n_hash     = r_hash;
        n_phase    = r_phase;
        n_hts      = r_hts;
        n_rule_ok  = r_rule_ok;
        n_after_cr = r_after_cr;
        if (accept) begin
            n_byte_ofs = r_byte_ofs + OFFSET_BITS'(1);
            n_after_cr = 1'b0;
            if (!swallow) begin
                if (is_term) begin
                    n_after_cr = is_cr;
                end else begin
                    n_start   = tk_start;
                    n_len     = tk_len;
                    n_trim    = tk_trim;
                    n_first   = tk_first;
                    n_hash    = tk_hash;
                    n_phase   = tk_phase;
                    n_hts     = tk_hts;
                    n_rule_ok = tk_rule_ok;
                end
                // Drop the line once it is closed
                if (is_term || i_tlast) begin
                    n_len     = '0;
                    n_trim    = '0;
                    n_first   = '0;
                    n_hash    = '0;
                    n_phase   = mlc_pkg::PH_COUNT;
                    n_hts     = '0;
                    n_rule_ok = 1'b1;
                end
            end
            // End of text: start over at offset zero
            if (i_tlast) begin
                n_byte_ofs = '0;
                n_start    = '0;
                n_after_cr = 1'b0;
                n_len      = '0;
                n_trim     = '0;
                n_first    = '0;
                n_hash     = '0;
                n_phase    = mlc_pkg::PH_COUNT;
                n_hts      = '0;
                n_rule_ok  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_ofs <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_trim     <= '0;
            r_first    <= '0;
            r_hash     <= '0;
            r_phase    <= mlc_pkg::PH_COUNT;
            r_hts      <= '0;
            r_rule_ok  <= 1'b1;
            r_after_cr <= 1'b0;
        end else begin
            r_byte_ofs <= n_byte_ofs;
            r_start    <= n_start;
            r_len      <= n_len;
            r_trim     <= n_trim;
            r_first    <= n_first;
            r_hash     <= n_hash;
            r_phase    <= n_phase;
            r_hts      <= n_hts;
            r_rule_ok  <= n_rule_ok;
            r_after_cr <= n_after_cr;
        end
    end

    // A text that ends restarts the offset count
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_tlast) |=> (r_byte_ofs == '0 && r_len == '0 && !r_after_cr))
        else $error("offset not restarted after last byte");

    // Trimmed length never runs ahead of an open line
    a_trim_needs_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len == '0) |-> (r_trim == '0))
        else $error("trimmed length set on empty line");

endmodule

[design/mlc_queue.sv]
// ----------------------------------------------------------------------------
// mlc_queue - two-entry record queue
// Decouples the byte scanner from the record formatter so that either side
// can stall on its own.
// ----------------------------------------------------------------------------
module mlc_queue #(
    parameter int DATA_W = 70
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_space,
    output logic              o_avail,
    output logic [DATA_W-1:0] o_data
);

    localparam int DEPTH = 2;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count, n_count;
    logic              do_push, do_pop;

    assign o_space = (r_count != 2'(DEPTH));
    assign o_avail = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_avail;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Fill level stays within the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue fill level beyond depth");

    // Pointers differ exactly when the queue holds one entry
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) == (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with fill level");

endmodule

[design/mlc_back.sv]
// ----------------------------------------------------------------------------
// mlc_back - record formatter and output register
// Works out offset and length of each queued line and holds the finished
// record until the downstream side takes it.
// ----------------------------------------------------------------------------
module mlc_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_avail,
    output logic                                o_pop,
    input  mlc_pkg::t_line_ctl                  i_ctl,
    input  logic [OFFSET_BITS-1:0]              i_hts,
    input  logic [OFFSET_BITS-1:0]              i_start,
    input  logic [OFFSET_BITS-1:0]              i_len,
    input  logic [OFFSET_BITS-1:0]              i_trim,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output mlc_pkg::t_line_kind                 o_kind,
    output logic [mlc_pkg::LEVEL_W-1:0]         o_level,
    output logic [mlc_pkg::FIELD_W-1:0]         o_offset,
    output logic [mlc_pkg::FIELD_W-1:0]         o_length
);

    localparam int FW = mlc_pkg::FIELD_W;

    logic                          r_valid;
    mlc_pkg::t_line_kind           r_kind;
    logic [mlc_pkg::LEVEL_W-1:0]   r_level;
    logic [FW-1:0]                 r_offset, r_length;

    logic [OFFSET_BITS-1:0]        end_ofs, f_ofs, f_len;
    logic [mlc_pkg::LEVEL_W-1:0]   f_level;
    logic                          load;

    // Load a new word whenever the output register is free or being emptied
    assign load  = i_avail && (!r_valid || i_tready);
    assign o_pop = load;

    assign end_ofs = i_start + i_len;

    // Format the record by kind
    always_comb begin
        f_ofs   = '0;
        f_len   = '0;
        f_level = '0;
        case (i_ctl.kind)
            mlc_pkg::KIND_HEADING: begin
                f_level = i_ctl.level;
                f_ofs   = i_ctl.text_found ? i_hts : end_ofs;
                f_len   = i_ctl.text_found ? (end_ofs - i_hts) : '0;
            end
            mlc_pkg::KIND_PARA: begin
                f_ofs = i_start;
                f_len = i_trim;
            end
            default: begin
                f_ofs = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold the payload until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_ctl.kind;
            r_level  <= f_level;
            r_offset <= FW'(f_ofs);
            r_length <= FW'(f_len);
        end
    end

    assign o_tvalid = r_valid;
    assign o_kind   = r_kind;
    assign o_level  = r_level;
    assign o_offset = r_offset;
    assign o_length = r_length;

    // Rule records carry no text position
    a_rule_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == mlc_pkg::KIND_RULE)
            |-> (r_offset == '0 && r_length == '0 && r_level == '0))
        else $error("rule record with nonzero fields");

    // Heading level is set exactly for headings
    a_level_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_kind == mlc_pkg::KIND_HEADING) == (r_level != '0)))
        else $error("heading level does not match kind");

endmodule
